FILE: src/dda_pkg.sv
// Shared types, constants and the arctangent table of the target approach block.
package dda_pkg;

   localparam int COORD_FRAC_BITS = 16;
   localparam int CORDIC_STEPS_DEF = 16;
   localparam int GUARD_BITS = 6;
   localparam int CX_W = 34;
   localparam int CZ_W = 20;
   localparam int ATAN_IDX_W = 5;
   localparam int MUL_A_W = 34;
   localparam int MUL_B_W = 18;
   localparam int PROD_W = MUL_A_W + MUL_B_W;
   localparam int ADDR_W = 5;
   localparam int TURN_SHIFT = 21 - COORD_FRAC_BITS;

   localparam logic signed [CZ_W-1:0] HALF_PI_Q16 = CZ_W'(102944);
   localparam logic signed [16:0] PI_Q13 = 17'sd25736;
   localparam logic [16:0] INV_GAIN_Q16 = 17'd39797;
   localparam logic [23:0] RANGE_MAX = 24'hFFFFFF;

   localparam logic [1:0] MODE_STOP = 2'd0;
   localparam logic [1:0] MODE_SPIN = 2'd1;
   localparam logic [1:0] MODE_STEER = 2'd2;
   localparam logic [1:0] MODE_STRAIGHT = 2'd3;

   localparam logic [2:0] REG_STAND_OFF = 3'd0;
   localparam logic [2:0] REG_ARRIVE_BAND = 3'd1;
   localparam logic [2:0] REG_TURN_LIMIT = 3'd2;
   localparam logic [2:0] REG_TURN_GAIN = 3'd3;
   localparam logic [2:0] REG_FWD_GAIN = 3'd4;
   localparam logic [2:0] REG_STEER_BAND = 3'd5;
   localparam logic [2:0] REG_SPEED_CAP = 3'd6;
   localparam logic [2:0] REG_SPIN_BAND = 3'd7;

   typedef struct packed {
      logic [22:0] stand_off_distance;
      logic [22:0] arrive_band;
      logic [19:0] turn_rate_limit;
      logic [15:0] turn_gain;
      logic [15:0] forward_gain;
      logic [14:0] steer_band;
      logic [19:0] forward_speed_cap;
      logic [14:0] spin_band;
   } cfg_type;

   // Arctangent of 2^-i in Q16 radians, rounded to nearest.
   function automatic logic signed [CZ_W-1:0] atan_q16(input logic [ATAN_IDX_W-1:0] idx);
      logic signed [CZ_W-1:0] v;
      unique case (idx)
         5'd0: v = CZ_W'(51472);
         5'd1: v = CZ_W'(30386);
         5'd2: v = CZ_W'(16055);
         5'd3: v = CZ_W'(8150);
         5'd4: v = CZ_W'(4091);
         5'd5: v = CZ_W'(2047);
         5'd6: v = CZ_W'(1024);
         5'd7: v = CZ_W'(512);
         5'd8: v = CZ_W'(256);
         5'd9: v = CZ_W'(128);
         5'd10: v = CZ_W'(64);
         5'd11: v = CZ_W'(32);
         5'd12: v = CZ_W'(16);
         5'd13: v = CZ_W'(8);
         5'd14: v = CZ_W'(4);
         5'd15: v = CZ_W'(2);
         5'd16: v = CZ_W'(1);
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

FILE: src/dda_regs.sv
// Configuration register file with its APB-style access port.
module dda_regs import dda_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready,
   output cfg_type           cfg
);

   cfg_type cfg_ff;
   logic    wr_en;
   logic [2:0] idx;

   assign idx    = paddr[ADDR_W-1:2];
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.stand_off_distance <= 23'd58982;
         cfg_ff.arrive_band        <= 23'd3277;
         cfg_ff.turn_rate_limit    <= 20'd19661;
         cfg_ff.turn_gain          <= 16'd384;
         cfg_ff.forward_gain       <= 16'd77;
         cfg_ff.steer_band         <= 15'd1229;
         cfg_ff.forward_speed_cap  <= 20'd5243;
         cfg_ff.spin_band          <= 15'd4096;
      end else if (wr_en) begin
         unique case (idx)
            REG_STAND_OFF:   cfg_ff.stand_off_distance <= pwdata[22:0];
            REG_ARRIVE_BAND: cfg_ff.arrive_band        <= pwdata[22:0];
            REG_TURN_LIMIT:  cfg_ff.turn_rate_limit    <= pwdata[19:0];
            REG_TURN_GAIN:   cfg_ff.turn_gain          <= pwdata[15:0];
            REG_FWD_GAIN:    cfg_ff.forward_gain       <= pwdata[15:0];
            REG_STEER_BAND:  cfg_ff.steer_band         <= pwdata[14:0];
            REG_SPEED_CAP:   cfg_ff.forward_speed_cap  <= pwdata[19:0];
            REG_SPIN_BAND:   cfg_ff.spin_band          <= pwdata[14:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_STAND_OFF:   prdata = 32'(cfg_ff.stand_off_distance);
         REG_ARRIVE_BAND: prdata = 32'(cfg_ff.arrive_band);
         REG_TURN_LIMIT:  prdata = 32'(cfg_ff.turn_rate_limit);
         REG_TURN_GAIN:   prdata = 32'(cfg_ff.turn_gain);
         REG_FWD_GAIN:    prdata = 32'(cfg_ff.forward_gain);
         REG_STEER_BAND:  prdata = 32'(cfg_ff.steer_band);
         REG_SPEED_CAP:   prdata = 32'(cfg_ff.forward_speed_cap);
         REG_SPIN_BAND:   prdata = 32'(cfg_ff.spin_band);
         default:         prdata = '0;
      endcase
   end

endmodule

FILE: src/dda_cordic.sv
// Iterative vectoring CORDIC: one shift-add step per cycle on a shared datapath.
module dda_cordic import dda_pkg::*; #(
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic signed [23:0]     fx,
   input  logic signed [23:0]     ly,
   output logic                   done,
   output logic signed [CX_W-1:0] x_out,
   output logic signed [CZ_W-1:0] z_out
);

   localparam int STEP_W = $clog2(CORDIC_STEPS);

   logic signed [CX_W-1:0] x_ff, x_in, y_ff, y_in, xs, ys, dx, dy;
   logic signed [CZ_W-1:0] z_ff, z_in, ang;
   logic [STEP_W-1:0]      step_ff, step_in;
   logic                   busy_ff, busy_in, done_ff, done_in, zero_ff, zero_in;
   logic                   last;

   assign xs = {{(CX_W-24-GUARD_BITS){fx[23]}}, fx, {GUARD_BITS{1'b0}}};
   assign ys = {{(CX_W-24-GUARD_BITS){ly[23]}}, ly, {GUARD_BITS{1'b0}}};
   assign dx = y_ff >>> step_ff;
   assign dy = x_ff >>> step_ff;
   assign ang = atan_q16(ATAN_IDX_W'(step_ff));
   assign last = (step_ff == STEP_W'(CORDIC_STEPS - 1));

   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      zero_in = zero_ff;
      if (start) begin
         zero_in = (fx == '0) && (ly == '0);
         step_in = '0;
         busy_in = 1'b1;
         if (fx < 0) begin
            // rotate into the right half plane
            if (ly >= 0) begin
               x_in = ys;
               y_in = -xs;
               z_in = HALF_PI_Q16;
            end else begin
               x_in = -ys;
               y_in = xs;
               z_in = -HALF_PI_Q16;
            end
         end else begin
            x_in = xs;
            y_in = ys;
            z_in = '0;
         end
      end else if (busy_ff) begin
         if (y_ff > 0) begin
            x_in = x_ff + dx;
            y_in = y_ff - dy;
            z_in = z_ff + ang;
         end else begin
            x_in = x_ff - dx;
            y_in = y_ff + dy;
            z_in = z_ff - ang;
         end
         step_in = step_ff + 1'b1;
         if (last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
         zero_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
         zero_ff <= zero_in;
      end
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
   end

   assign done  = done_ff;
   assign x_out = zero_ff ? '0 : x_ff;
   assign z_out = zero_ff ? '0 : z_ff;

endmodule

FILE: src/differential_drive_target_approach.sv
// Drive command generator for a differential-drive robot approaching a target.
//
// Input channel (req_*): one word is either a mode event (req_cmd = 1, req_approach_on)
// or a target point (req_cmd = 0, forward and lateral offsets in 1/65536 m).
// Result channel (rsp_*): at most one drive command per input word: forward speed,
// turn rate, drive mode, arrival pulse and measured range.
// Configuration: APB-style port, register i at byte address 4*i, pready always high.
// Mode events and points answered with a plain stop are handled in the idle state.
// A target point goes through the iterative CORDIC (state S_POLAR) and then the
// post-processing states S_RANGE, S_TURN, S_SPEED and S_DONE, which share one
// multiplier with S_POLAR; the result is offered from S_DONE, which waits there
// while the output register is full, and the next word is taken only once the
// block is back in S_IDLE; one point at a time.
// A finished word sits in the output register; the next input word is taken
// only in a cycle in which that register is empty or being read.
// When the receiver stalls, the finished word holds in the output register and
// the input stays blocked. Reset clears the mode flags, the handshakes and
// loads the register defaults; no clearing pass is needed.
module differential_drive_target_approach import dda_pkg::*; #(
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_cmd,
   input  logic signed [23:0] req_forward_offset,
   input  logic signed [23:0] req_lateral_offset,
   input  logic              req_approach_on,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [19:0]       rsp_forward_speed,
   output logic signed [20:0] rsp_turn_rate,
   output logic [1:0]        rsp_drive_mode,
   output logic              rsp_arrived_pulse,
   output logic [23:0]       rsp_measured_range,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   typedef enum logic [2:0] {
      S_IDLE, S_POLAR, S_RANGE, S_TURN, S_SPEED, S_DONE
   } state_type;

   state_type state_ff, state_in;
   cfg_type   cfg;

   logic approach_ff, approach_in, halted_ff, halted_in, reported_ff, reported_in;
   logic rsp_valid_ff, rsp_valid_in, slot_free, accept, cordic_start, cordic_done;
   logic [19:0] speed_ff, speed_in;
   logic signed [20:0] turn_ff, turn_in, turn_calc;
   logic [1:0] mode_ff, mode_in;
   logic pulse_ff, pulse_in;
   logic [23:0] range_out_ff, range_out_in;

   logic signed [CX_W-1:0] cx;
   logic signed [CZ_W-1:0] cz;
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [PROD_W-1:0] prod_ff, rnd_sum, rng_sh, turn_sh, speed_sh;
   logic signed [CZ_W-1:0] zb;
   logic [23:0] range_ff, range_in;
   logic signed [16:0] bear_ff, bear_in;
   logic signed [24:0] err_ff, err_in;
   logic [24:0] err_mag;
   logic [16:0] bear_mag;
   logic signed [21:0] lim;

   dda_regs u_regs (
      .clock(clock), .reset(reset), .psel(psel), .penable(penable), .pwrite(pwrite),
      .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
   );

   dda_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
      .clock(clock), .reset(reset), .start(cordic_start),
      .fx(req_forward_offset), .ly(req_lateral_offset),
      .done(cordic_done), .x_out(cx), .z_out(cz)
   );

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && slot_free;
   assign accept    = req_valid && req_ready;

   // shared multiplier, operands picked by the sequencer
   always_comb begin
      unique case (state_ff)
         S_POLAR: begin
            mul_a = MUL_A_W'(cx);
            mul_b = MUL_B_W'(INV_GAIN_Q16);
         end
         S_TURN: begin
            mul_a = MUL_A_W'(bear_ff);
            mul_b = MUL_B_W'(cfg.turn_gain);
         end
         default: begin
            mul_a = MUL_A_W'(err_ff);
            mul_b = MUL_B_W'(cfg.forward_gain);
         end
      endcase
   end

   assign rnd_sum  = prod_ff + PROD_W'(64'sd1 <<< (15 + GUARD_BITS));
   assign rng_sh   = rnd_sum >>> (16 + GUARD_BITS);
   assign zb       = (cz + CZ_W'(4)) >>> 3;
   assign turn_sh  = prod_ff >>> TURN_SHIFT;
   assign speed_sh = prod_ff >>> 8;
   assign lim      = 22'(cfg.turn_rate_limit);
   assign err_mag  = err_ff[24] ? 25'(-err_ff) : 25'(err_ff);
   assign bear_mag = bear_ff[16] ? 17'(-bear_ff) : 17'(bear_ff);

   always_comb begin
      if (rng_sh < 0) range_in = '0;
      else if (rng_sh > PROD_W'(RANGE_MAX)) range_in = RANGE_MAX;
      else range_in = rng_sh[23:0];
      if (zb > CZ_W'(PI_Q13)) bear_in = PI_Q13;
      else if (zb < -CZ_W'(PI_Q13)) bear_in = -PI_Q13;
      else bear_in = zb[16:0];
      err_in = 25'(range_ff) - 25'(cfg.stand_off_distance);
      if (turn_sh > PROD_W'(lim)) turn_calc = lim[20:0];
      else if (turn_sh < -PROD_W'(lim)) turn_calc = 21'(-lim);
      else turn_calc = turn_sh[20:0];
   end

   always_comb begin
      state_in     = state_ff;
      approach_in  = approach_ff;
      halted_in    = halted_ff;
      reported_in  = reported_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      speed_in     = speed_ff;
      turn_in      = turn_ff;
      mode_in      = mode_ff;
      pulse_in     = pulse_ff;
      range_out_in = range_out_ff;
      cordic_start = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_cmd) begin
                  approach_in = req_approach_on;
                  if (req_approach_on) begin
                     halted_in = 1'b0;
                  end else begin
                     halted_in   = 1'b1;
                     reported_in = 1'b0;
                     if (!halted_ff) begin
                        rsp_valid_in = 1'b1;
                        speed_in = '0; turn_in = '0; mode_in = MODE_STOP;
                        pulse_in = 1'b0; range_out_in = '0;
                     end
                  end
               end else if (!approach_ff) begin
                  halted_in    = 1'b1;
                  rsp_valid_in = 1'b1;
                  speed_in = '0; turn_in = '0; mode_in = MODE_STOP;
                  pulse_in = 1'b0; range_out_in = '0;
               end else if (!halted_ff) begin
                  cordic_start = 1'b1;
                  state_in     = S_POLAR;
               end
            end
         end
         S_POLAR: if (cordic_done) state_in = S_RANGE;
         S_RANGE: state_in = S_TURN;
         S_TURN:  state_in = S_SPEED;
         S_SPEED: state_in = S_DONE;
         S_DONE: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               range_out_in = range_ff;
               pulse_in     = 1'b0;
               state_in     = S_IDLE;
               if (err_mag < 25'(cfg.arrive_band)) begin
                  pulse_in    = !reported_ff;
                  halted_in   = 1'b1;
                  reported_in = 1'b1;
                  speed_in = '0; turn_in = '0; mode_in = MODE_STOP;
               end else begin
                  reported_in = 1'b0;
                  if (speed_sh < 0) speed_in = '0;
                  else if (speed_sh > PROD_W'(cfg.forward_speed_cap))
                     speed_in = cfg.forward_speed_cap;
                  else speed_in = speed_sh[19:0];
                  if (bear_mag > 17'(cfg.spin_band)) begin
                     speed_in = '0;
                     mode_in  = MODE_SPIN;
                  end else if (bear_mag > 17'(cfg.steer_band)) begin
                     mode_in = MODE_STEER;
                  end else begin
                     turn_in = '0;
                     mode_in = MODE_STRAIGHT;
                  end
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         approach_ff  <= 1'b0;
         halted_ff    <= 1'b0;
         reported_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         approach_ff  <= approach_in;
         halted_ff    <= halted_in;
         reported_ff  <= reported_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      prod_ff      <= mul_a * mul_b;
      if (state_ff == S_RANGE) begin
         range_ff <= range_in;
         bear_ff  <= bear_in;
      end
      if (state_ff == S_TURN) err_ff <= err_in;
      if (state_ff == S_SPEED) turn_ff <= turn_calc;
      else turn_ff <= turn_in;
      speed_ff     <= speed_in;
      mode_ff      <= mode_in;
      pulse_ff     <= pulse_in;
      range_out_ff <= range_out_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_forward_speed  = speed_ff;
   assign rsp_turn_rate      = turn_ff;
   assign rsp_drive_mode     = mode_ff;
   assign rsp_arrived_pulse  = pulse_ff;
   assign rsp_measured_range = range_out_ff;

   a_stop_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_drive_mode == MODE_STOP |-> rsp_forward_speed == '0 && rsp_turn_rate == '0)
      else $error("stop command carries nonzero speed or turn");

   a_pulse_stop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_arrived_pulse |-> rsp_drive_mode == MODE_STOP)
      else $error("arrival pulse outside a stop command");

   a_spin_speed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_drive_mode == MODE_SPIN |-> rsp_forward_speed == '0)
      else $error("turn in place with forward speed");

   a_turn_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_turn_rate <= lim) && (rsp_turn_rate >= -lim))
      else $error("turn rate beyond limit");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      cordic_start |=> !req_ready)
      else $error("input taken while a point is in progress");

endmodule

FILE: tb/tb_differential_drive_target_approach.sv
// Self-checking testbench of the differential-drive target approach block.
module tb_differential_drive_target_approach;
   import dda_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STEPS = 16;
   localparam int DRAIN_CYCLES = 40;
   localparam int CYCLE_LIMIT = 600000;

   typedef struct {
      logic        cmd;
      logic [23:0] fwd;
      logic [23:0] lat;
      logic        on;
   } word_type;

   typedef struct {
      logic [19:0] speed;
      logic [20:0] turn;
      logic [1:0]  mode;
      logic        pulse;
      logic [23:0] range;
   } drive_type;

   logic clock = 0, reset = 1;
   logic req_valid = 0, req_cmd = 0, req_approach_on = 0;
   logic signed [23:0] req_forward_offset = 0, req_lateral_offset = 0;
   logic req_ready, rsp_valid, rsp_ready = 0;
   logic [19:0] rsp_forward_speed;
   logic signed [20:0] rsp_turn_rate;
   logic [1:0] rsp_drive_mode;
   logic rsp_arrived_pulse;
   logic [23:0] rsp_measured_range;
   logic psel = 0, penable = 0, pwrite = 0;
   logic [ADDR_W-1:0] paddr = 0;
   logic [31:0] pwdata = 0, prdata;
   logic pready;

   differential_drive_target_approach DUT (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   word_type  pending_words[$];
   drive_type expected_cmds[$];
   word_type  cur_word;
   int     errors = 0, words_sent = 0, cmds_seen = 0, arrivals_seen = 0;
   bit     quiet = 0, hold_req = 0, hold_done = 0;

   // predictor copy of registers and flags
   cfg_type cfg;
   bit      appr, halt, reported;

   const longint atan_tab[17] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                                   256, 128, 64, 32, 16, 8, 4, 2, 1};

   function automatic longint clampl(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic void to_polar(longint fx, longint ly, output longint rng,
                                    output longint brg);
      longint x, y, z, t, dx, dy;
      x = fx * 64; y = ly * 64; z = 0;
      if (fx == 0 && ly == 0) begin
         rng = 0; brg = 0;
         return;
      end
      if (x < 0) begin
         t = x;
         if (y >= 0) begin x = y; y = -t; z = 102944; end
         else begin x = -y; y = t; z = -102944; end
      end
      for (int i = 0; i < STEPS; i++) begin
         dx = y >>> i; dy = x >>> i;
         if (y > 0) begin x += dx; y -= dy; z += atan_tab[i]; end
         else begin x -= dx; y += dy; z -= atan_tab[i]; end
      end
      t = (x * 39797 + (longint'(1) << 21)) >>> 22;
      rng = clampl(t, 0, 24'hFFFFFF);
      brg = clampl((z + 4) >>> 3, -25736, 25736);
   endfunction

   function automatic void push_cmd(longint s, longint t, logic [1:0] m, bit p,
                                    longint r);
      drive_type d;
      d.speed = s[19:0]; d.turn = t[20:0]; d.mode = m; d.pulse = p; d.range = r[23:0];
      expected_cmds = {expected_cmds, d};
   endfunction

   function automatic void predict_drive(word_type w);
      longint rng, brg, err, mag, turn, speed, lim;
      if (w.cmd) begin
         appr = w.on;
         if (!appr) begin
            if (!halt) push_cmd(0, 0, MODE_STOP, 0, 0);
            halt = 1; reported = 0;
         end else halt = 0;
         return;
      end
      if (!appr) begin
         halt = 1;
         push_cmd(0, 0, MODE_STOP, 0, 0);
         return;
      end
      if (halt) return;
      to_polar(longint'(signed'(w.fwd)), longint'(signed'(w.lat)), rng, brg);
      err = rng - longint'(cfg.stand_off_distance);
      mag = err < 0 ? -err : err;
      if (mag < longint'(cfg.arrive_band)) begin
         push_cmd(0, 0, MODE_STOP, !reported, rng);
         halt = 1; reported = 1;
         return;
      end
      reported = 0;
      lim = longint'(cfg.turn_rate_limit);
      turn = clampl((longint'(cfg.turn_gain) * brg) >>> TURN_SHIFT, -lim, lim);
      speed = clampl((longint'(cfg.forward_gain) * err) >>> 8, 0,
                     longint'(cfg.forward_speed_cap));
      mag = brg < 0 ? -brg : brg;
      if (mag > longint'(cfg.spin_band)) push_cmd(0, turn, MODE_SPIN, 0, rng);
      else if (mag > longint'(cfg.steer_band)) push_cmd(speed, turn, MODE_STEER, 0, rng);
      else push_cmd(speed, 0, MODE_STRAIGHT, 0, rng);
   endfunction

   // sender: predict on acceptance, then offer the next word or idle
   int send_gap = 0;
   always @(posedge clock) begin
      logic nv;
      nv = req_valid;
      if (reset) nv = 0;
      else begin
         if (req_valid && req_ready) begin
            predict_drive(cur_word);
            words_sent++;
            nv = 0;
         end
         if (!nv) begin
            if (send_gap > 0) send_gap--;
            else if (!quiet && $urandom_range(0, 15) == 0) send_gap = $urandom_range(0, 15);
            else if (pending_words.size() > 0) begin
               cur_word = pending_words.pop_front();
               req_cmd <= cur_word.cmd;
               req_forward_offset <= cur_word.fwd;
               req_lateral_offset <= cur_word.lat;
               req_approach_on <= cur_word.on;
               nv = 1;
            end
         end
      end
      req_valid <= nv;
   end

   // receiver: check each accepted word, then choose ready for the next cycle
   int stall_gap = 0, hold_cnt = 0;
   always @(posedge clock) begin
      drive_type e;
      logic nr;
      if (!reset && rsp_valid && rsp_ready) begin
         cmds_seen++;
         if (rsp_arrived_pulse) arrivals_seen++;
         if (expected_cmds.size() == 0) begin
            errors++;
            $display("%0t unexpected word: range %0d mode %0d", $realtime,
                     rsp_measured_range, rsp_drive_mode);
         end else begin
            e = expected_cmds.pop_front();
            if (rsp_forward_speed !== e.speed) begin
               errors++;
               $display("%0t forward_speed exp %0d got %0d", $realtime, e.speed,
                        rsp_forward_speed);
            end
            if (rsp_turn_rate !== e.turn) begin
               errors++;
               $display("%0t turn_rate exp %0d got %0d", $realtime, signed'(e.turn),
                        rsp_turn_rate);
            end
            if (rsp_drive_mode !== e.mode) begin
               errors++;
               $display("%0t drive_mode exp %0d got %0d", $realtime, e.mode, rsp_drive_mode);
            end
            if (rsp_arrived_pulse !== e.pulse) begin
               errors++;
               $display("%0t arrived_pulse exp %0d got %0d", $realtime, e.pulse,
                        rsp_arrived_pulse);
            end
            if (rsp_measured_range !== e.range) begin
               errors++;
               $display("%0t measured_range exp %0d got %0d", $realtime, e.range,
                        rsp_measured_range);
            end
         end
      end
      nr = 1;
      if (reset) nr = 0;
      else if (hold_req && !hold_done) begin
         // hold off long enough for the block to fill and stall its input
         hold_cnt++;
         nr = 0;
         if (hold_cnt >= 400) hold_done = 1;
      end else if (stall_gap > 0) begin
         stall_gap--;
         nr = 0;
      end else if (!quiet && $urandom_range(0, 11) == 0) begin
         stall_gap = $urandom_range(0, 15);
         nr = 0;
      end
      rsp_ready <= nr;
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("status: fail");
      $finish;
   end

   task automatic csr_write(logic [2:0] idx, logic [31:0] val);
      @(posedge clock);
      psel <= 1; pwrite <= 1; penable <= 0;
      paddr <= ADDR_W'({idx, 2'b00}); pwdata <= val;
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      psel <= 0; penable <= 0; pwrite <= 0;
      case (idx)
         REG_STAND_OFF:   cfg.stand_off_distance = val[22:0];
         REG_ARRIVE_BAND: cfg.arrive_band = val[22:0];
         REG_TURN_LIMIT:  cfg.turn_rate_limit = val[19:0];
         REG_TURN_GAIN:   cfg.turn_gain = val[15:0];
         REG_FWD_GAIN:    cfg.forward_gain = val[15:0];
         REG_STEER_BAND:  cfg.steer_band = val[14:0];
         REG_SPEED_CAP:   cfg.forward_speed_cap = val[19:0];
         default:         cfg.spin_band = val[14:0];
      endcase
   endtask

   task automatic load_cfg(cfg_type c);
      csr_write(REG_STAND_OFF, 32'(c.stand_off_distance));
      csr_write(REG_ARRIVE_BAND, 32'(c.arrive_band));
      csr_write(REG_TURN_LIMIT, 32'(c.turn_rate_limit));
      csr_write(REG_TURN_GAIN, 32'(c.turn_gain));
      csr_write(REG_FWD_GAIN, 32'(c.forward_gain));
      csr_write(REG_STEER_BAND, 32'(c.steer_band));
      csr_write(REG_SPEED_CAP, 32'(c.forward_speed_cap));
      csr_write(REG_SPIN_BAND, 32'(c.spin_band));
   endtask

   task automatic drain;
      do begin
         @(posedge clock);
         #1;
      end while (pending_words.size() > 0 || req_valid || expected_cmds.size() > 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic void add(bit c, int f, int l, bit o);
      word_type w;
      w.cmd = c; w.fwd = f[23:0]; w.lat = l[23:0]; w.on = o;
      pending_words = {pending_words, w};
   endfunction

   function automatic int rand_coord();
      case ($urandom_range(0, 3))
         0: return int'(signed'(24'($urandom)));
         1: return $urandom_range(0, 2000) - 1000;
         2: return $urandom_range(0, 400000) - 200000;
         default: return $urandom_range(0, 1) ? 8388607 - $urandom_range(0, 3)
                                              : -8388608 + $urandom_range(0, 3);
      endcase
   endfunction

   // mostly approach sequences, with points near the stand-off and some noise
   function automatic void random_words(int n);
      int so, d;
      so = int'(cfg.stand_off_distance);
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 19))
            0: add(1, $urandom, $urandom, 0);
            1, 2: add(1, $urandom, $urandom, 1);
            3: add(0, rand_coord(), rand_coord(), 1'($urandom));
            4, 5: begin
               d = int'(cfg.arrive_band) + 200;
               add(0, so + $urandom_range(0, 2 * d) - d, $urandom_range(0, 200) - 100,
                   1'($urandom));
            end
            default: add(0, rand_coord(), rand_coord(), 1'($urandom));
         endcase
      end
   endfunction

   initial begin
      cfg_type c;
      cfg = '{58982, 3277, 19661, 384, 77, 1229, 5243, 4096};
      appr = 0; halt = 0; reported = 0;
      repeat (4) @(posedge clock);
      reset <= 0;
      load_cfg(cfg);

      // directed: stops, extremes, quadrants, three arrivals with two pulses
      add(1, 0, 0, 0);
      add(1, 0, 0, 0);
      add(0, 100, 100, 0);
      add(1, 0, 0, 1);
      add(0, 0, 0, 0);
      add(0, 8388607, 8388607, 0);
      add(0, -8388608, -8388608, 0);
      add(0, -8388608, 8388607, 0);
      add(0, 8388607, -8388608, 0);
      add(0, -1000, 5, 0);
      add(0, -1000, -5, 0);
      add(0, 0, -300000, 0);
      add(0, 300000, 10, 0);
      add(0, 58982, 0, 0);
      add(0, 58982, 0, 1);
      add(1, 0, 0, 1);
      add(0, 58990, 3, 0);
      add(1, 0, 0, 1);
      add(0, 200000, 0, 0);
      add(0, 58982, 0, 0);
      add(1, 0, 0, 0);
      add(0, 1, 1, 0);
      drain();

      random_words(250);
      drain();

      c = '{23'h7FFFFF, 23'h7FFFFF, 20'hFFFFF, 16'hFFFF, 16'hFFFF, 25736, 20'hFFFFF, 25736};
      load_cfg(c);
      random_words(150);
      drain();

      c = '{0, 0, 0, 0, 0, 0, 0, 0};
      load_cfg(c);
      random_words(150);
      drain();

      // receiver holds off while the sender keeps offering
      hold_req = 1;
      load_cfg('{58982, 3277, 19661, 384, 77, 1229, 5243, 4096});
      random_words(200);
      drain();

      for (int p = 0; p < 3; p++) begin
         c.stand_off_distance = 23'($urandom_range(0, 400000));
         c.arrive_band = 23'($urandom_range(0, 20000));
         c.turn_rate_limit = 20'($urandom_range(0, 20'hFFFFF));
         c.turn_gain = 16'($urandom);
         c.forward_gain = 16'($urandom);
         c.steer_band = 15'($urandom_range(0, 25736));
         c.forward_speed_cap = 20'($urandom_range(0, 20'hFFFFF));
         c.spin_band = 15'($urandom_range(0, 25736));
         load_cfg(c);
         random_words(150);
         drain();
      end

      quiet = 1;
      random_words(250);
      drain();

      $display("covered %0d words, %0d drive commands, %0d arrival pulses", words_sent,
               cmds_seen, arrivals_seen);
      $display("settings: reset values, all-max, all-zero and three random sets");
      if (errors == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end
endmodule

FILE: files.f
src/dda_pkg.sv
src/dda_regs.sv
src/dda_cordic.sv
src/differential_drive_target_approach.sv
tb/tb_differential_drive_target_approach.sv
